/* design/hmpc_pkg.sv */
// ----------------------------------------------------------------------------
// Hex match pattern compiler package
// Shared codes, constants, the stage transaction type and decode functions.
// ----------------------------------------------------------------------------
package hmpc_pkg;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_RAW  = 1'b1;

  localparam logic [7:0] LEN_ONE   = 8'd1;
  localparam logic [7:0] LEN_TWO   = 8'd2;
  localparam logic [7:0] LEN_THREE = 8'd3;

  localparam logic [2:0] CNT_TWO  = 3'd2;
  localparam logic [2:0] CNT_FOUR = 3'd4;
  localparam logic [2:0] CNT_SIX  = 3'd6;
  localparam logic [2:0] CNT_SAT  = 3'd7;

  localparam logic [23:0] MASK_ONE   = 24'h0000FF;
  localparam logic [23:0] MASK_TWO   = 24'h00FFFF;
  localparam logic [23:0] MASK_THREE = 24'hFFFFFF;

  localparam logic [7:0] NUL_CHAR    = 8'h00;
  localparam logic [7:0] BYTE_TOP    = 8'hFF;
  localparam logic [3:0] ALPHA_BIAS  = 4'd9;
  localparam int         UNMATCH_SPAN = 5;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } hmpc_word_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      res = {1'b1, 4'(ch[3:0] + ALPHA_BIAS)};
    end
    return res;
  endfunction

  // Largest byte value that is none of the four bytes of the word.
  function automatic logic [7:0] unmatch_byte(input logic [31:0] word);
    logic [7:0] res;
    logic [7:0] cand;
    logic       found;
    logic       hit;
    res   = BYTE_TOP;
    found = 1'b0;
    for (int i = 0; i < UNMATCH_SPAN; i++) begin
      cand = 8'(BYTE_TOP - 8'(i));
      hit  = (word[7:0] == cand) || (word[15:8] == cand) ||
             (word[23:16] == cand) || (word[31:24] == cand);
      if (!found && !hit) begin
        res   = cand;
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

/* design/hex_match_pattern_compiler.sv */
// A string end or word load is registered in the input stage, then in the output register.
// Throughput: one input transaction per cycle while in_stall is low, set by the two registered stages.
// A result held at the output stalls the input only once a second result waits in the input stage.
// Reset (synchronous, rst_n low) clears the string state, the terminator and both stage valids.
// ----------------------------------------------------------------------------
// Hex match pattern compiler
// Compiles hex pattern strings, or raw pattern words, into matcher values.
// ----------------------------------------------------------------------------
module hex_match_pattern_compiler
  import hmpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_end_char,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_raw_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pattern_word,
  output logic [7:0]  out_pattern_length,
  output logic [23:0] out_match_mask,
  output logic [23:0] out_target_value,
  output logic [31:0] out_unmatch_word
);

  hmpc_word_t s1;
  logic       adv;

  assign cfg_ready = 1'b1;

  hmpc_str_asm u_str_asm (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_end_char (cfg_end_char),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .in_raw_word  (in_raw_word),
    .adv          (adv),
    .s1           (s1)
  );

  hmpc_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .s1                 (s1),
    .adv                (adv),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pattern_word   (out_pattern_word),
    .out_pattern_length (out_pattern_length),
    .out_match_mask     (out_match_mask),
    .out_target_value   (out_target_value),
    .out_unmatch_word   (out_unmatch_word)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1.valid && out_valid && out_stall))
    else $error("Input stalled while a stage was free.");

  a_raw_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_RAW) |=> s1.valid)
    else $error("Raw load transaction was lost.");

  a_invalid_len_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pattern_length == 8'd0) |->
      (out_match_mask == 24'd0 && out_target_value == 24'd0))
    else $error("Zero length result carries a mask or target.");

  a_fill_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_unmatch_word[7:0] != out_pattern_word[7:0] &&
                   out_unmatch_word[7:0] != out_pattern_word[31:24]))
    else $error("Fill byte occurs in the pattern word.");
`endif

endmodule

/* design/hmpc_str_asm.sv */
// ----------------------------------------------------------------------------
// Hex match pattern string assembler
// Holds the terminator register and the string state, and registers the
// packed pattern word of every transaction that produces a result.
// ----------------------------------------------------------------------------
module hmpc_str_asm
  import hmpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_end_char,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_raw_word,
  input  logic        adv,
  output hmpc_word_t  s1
);

  logic [7:0]  end_char_r;
  logic [2:0]  char_count_r, char_count_nxt;
  logic [23:0] digit_store_r, digit_store_nxt;
  logic        bad_seen_r, bad_seen_nxt;
  logic        valid_r, valid_nxt;
  logic [31:0] word_r, word_nxt;
  logic        load;
  logic        accept;
  logic [4:0]  dec;
  logic [31:0] built;

  assign load     = !valid_r || adv;
  assign in_stall = !load;
  assign accept   = in_valid && load;
  assign dec      = hex_nibble(in_char_code);

  always_comb begin
    built = 32'd0;
    if (!bad_seen_r) begin
      unique case (char_count_r)
        CNT_TWO:  built = {LEN_ONE, 16'd0, digit_store_r[7:0]};
        CNT_FOUR: built = {LEN_TWO, 8'd0, digit_store_r[7:0], digit_store_r[15:8]};
        CNT_SIX:  built = {LEN_THREE, digit_store_r[7:0], digit_store_r[15:8],
                           digit_store_r[23:16]};
        default:  built = 32'd0;
      endcase
    end
  end

  always_comb begin
    char_count_nxt  = char_count_r;
    digit_store_nxt = digit_store_r;
    bad_seen_nxt    = bad_seen_r;
    valid_nxt       = load ? 1'b0 : valid_r;
    word_nxt        = word_r;
    if (accept) begin
      if (in_op == OP_RAW) begin
        valid_nxt = 1'b1;
        word_nxt  = in_raw_word;
      end else if (in_char_code == end_char_r || in_char_code == NUL_CHAR) begin
        valid_nxt       = 1'b1;
        word_nxt        = (in_char_code == end_char_r) ? built : 32'd0;
        char_count_nxt  = 3'd0;
        digit_store_nxt = 24'd0;
        bad_seen_nxt    = 1'b0;
      end else begin
        if (!dec[4]) begin
          bad_seen_nxt = 1'b1;
        end
        if (char_count_r < CNT_SIX) begin
          digit_store_nxt = {digit_store_r[19:0], dec[3:0]};
        end
        if (char_count_r != CNT_SAT) begin
          char_count_nxt = 3'(char_count_r + 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_char_r    <= 8'd0;
      char_count_r  <= 3'd0;
      digit_store_r <= 24'd0;
      bad_seen_r    <= 1'b0;
      valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        end_char_r <= cfg_end_char;
      end
      char_count_r  <= char_count_nxt;
      digit_store_r <= digit_store_nxt;
      bad_seen_r    <= bad_seen_nxt;
      valid_r       <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign s1.valid = valid_r;
  assign s1.word  = word_r;

endmodule

/* design/hmpc_emit.sv */
// ----------------------------------------------------------------------------
// Hex match pattern result stage
// Derives length, match mask, target value and the fill word from a packed
// pattern word and holds them in the output register.
// ----------------------------------------------------------------------------
module hmpc_emit
  import hmpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  hmpc_word_t  s1,
  output logic        adv,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pattern_word,
  output logic [7:0]  out_pattern_length,
  output logic [23:0] out_match_mask,
  output logic [23:0] out_target_value,
  output logic [31:0] out_unmatch_word
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] word_r;
  logic [23:0] mask_r, mask_nxt;
  logic [23:0] target_r, target_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  len;

  assign adv           = !out_valid_r || !out_stall;
  assign out_valid_nxt = adv ? s1.valid : out_valid_r;
  assign len           = s1.word[31:24];
  assign fill_nxt      = unmatch_byte(s1.word);

  always_comb begin
    unique case (len)
      LEN_ONE: begin
        mask_nxt   = MASK_ONE;
        target_nxt = {16'd0, s1.word[7:0]};
      end
      LEN_TWO: begin
        mask_nxt   = MASK_TWO;
        target_nxt = {8'd0, s1.word[7:0], s1.word[15:8]};
      end
      LEN_THREE: begin
        mask_nxt   = MASK_THREE;
        target_nxt = {s1.word[7:0], s1.word[15:8], s1.word[23:16]};
      end
      default: begin
        mask_nxt   = 24'd0;
        target_nxt = 24'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1.valid) begin
      word_r   <= s1.word;
      mask_r   <= mask_nxt;
      target_r <= target_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pattern_word   = word_r;
  assign out_pattern_length = word_r[31:24];
  assign out_match_mask     = mask_r;
  assign out_target_value   = target_r;
  assign out_unmatch_word   = {fill_r, fill_r, fill_r, fill_r};

endmodule
